// ===== hdl/bounded_array_list_core_assert.svh =====
// Assertion macros for the bounded array list core.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef BOUNDED_ARRAY_LIST_CORE_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bal_pkg.sv =====
// Shared types and codes for the bounded array list core.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package bal_pkg;

  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;
  localparam int ST_W   = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INS   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ERASE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  localparam logic signed [WORD_W-1:0] ERR_WORD = -32'sd1;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_PUSH  = 2'd1;
  localparam logic [1:0] WR_SHIFT = 2'd2;
  localparam logic [1:0] WR_INS   = 2'd3;

  localparam logic [2:0] RD_NONE     = 3'd0;
  localparam logic [2:0] RD_POP      = 3'd1;
  localparam logic [2:0] RD_POS      = 3'd2;
  localparam logic [2:0] RD_UP_FIRST = 3'd3;
  localparam logic [2:0] RD_UP_NEXT  = 3'd4;
  localparam logic [2:0] RD_DN_FIRST = 3'd5;
  localparam logic [2:0] RD_DN_NEXT  = 3'd6;
  localparam logic [2:0] RD_FINAL    = 3'd7;

  typedef struct packed {
    logic       latch;
    logic       set_data;
    logic       cap_data;
    logic [1:0] wr_op;
    logic [2:0] rd_op;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
  } bal_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic             op_ok;
    logic             up_last;
    logic             dn_last;
    logic             ers_tail;
    logic             out_free;
  } bal_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bal_in_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
// Depends on bal_pkg for field widths.
`default_nettype none

interface bal_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [bal_pkg::REQ_W-1:0]              req_type;
  logic [bal_pkg::POS_W-1:0]              position;
  logic signed [bal_pkg::WORD_W-1:0]      value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink (input valid, input req_type, input position, input value,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/bal_out_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on bal_pkg for field widths; CNT_W sizes the count field.
`default_nettype none

interface bal_out_if #(
  parameter int CNT_W = 7
);
  logic                                   valid;
  logic                                   ready;
  logic signed [bal_pkg::WORD_W-1:0]      read_data;
  logic [bal_pkg::ST_W-1:0]               status;
  logic [CNT_W-1:0]                       count;
  logic signed [bal_pkg::WORD_W-1:0]      front_value;
  logic signed [bal_pkg::WORD_W-1:0]      back_value;

  modport source (output valid, output read_data, output status, output count,
                  output front_value, output back_value, input ready);
  modport sink (input valid, input read_data, input status, input count,
                input front_value, input back_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/bal_ctrl.sv =====
// Sequencer for the bounded array list: one request at a time, issues
// memory, count and output commands to bal_dp. Depends on bal_pkg.
`default_nettype none

module bal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bal_pkg::bal_sts_t sts,
  output bal_pkg::bal_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_DATA     = 3'd2;
  localparam logic [2:0] S_SHIFT_UP = 3'd3;
  localparam logic [2:0] S_INS_WR   = 3'd4;
  localparam logic [2:0] S_SHIFT_DN = 3'd5;
  localparam logic [2:0] S_FIN_RD   = 3'd6;
  localparam logic [2:0] S_FIN      = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_data = 1'b1;
        state_nxt    = S_FIN_RD;
        if (sts.op_ok) begin
          case (sts.kind)
            bal_pkg::REQ_PUSH: begin
              cmd.wr_op   = bal_pkg::WR_PUSH;
              cmd.cnt_inc = 1'b1;
            end
            bal_pkg::REQ_POP: begin
              cmd.rd_op   = bal_pkg::RD_POP;
              cmd.cnt_dec = 1'b1;
              state_nxt   = S_DATA;
            end
            bal_pkg::REQ_READ: begin
              cmd.rd_op = bal_pkg::RD_POS;
              state_nxt = S_DATA;
            end
            bal_pkg::REQ_INS: begin
              cmd.rd_op = bal_pkg::RD_UP_FIRST;
              state_nxt = S_SHIFT_UP;
            end
            bal_pkg::REQ_ERASE: begin
              if (sts.ers_tail) begin
                cmd.cnt_dec = 1'b1;
              end else begin
                cmd.rd_op = bal_pkg::RD_DN_FIRST;
                state_nxt = S_SHIFT_DN;
              end
            end
            default: begin
              state_nxt = S_FIN_RD;
            end
          endcase
        end
      end
      S_DATA: begin
        cmd.cap_data = 1'b1;
        state_nxt    = S_FIN_RD;
      end
      S_SHIFT_UP: begin
        cmd.wr_op = bal_pkg::WR_SHIFT;
        if (sts.up_last) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.rd_op = bal_pkg::RD_UP_NEXT;
        end
      end
      S_INS_WR: begin
        cmd.wr_op   = bal_pkg::WR_INS;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN_RD;
      end
      S_SHIFT_DN: begin
        cmd.wr_op = bal_pkg::WR_SHIFT;
        if (sts.dn_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN_RD;
        end else begin
          cmd.rd_op = bal_pkg::RD_DN_NEXT;
        end
      end
      S_FIN_RD: begin
        cmd.rd_op = bal_pkg::RD_FINAL;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bal_dp.sv =====
// Datapath for the bounded array list: entry memory, count, shift index,
// request latch and result register. Depends on bal_pkg and the assert header.
`default_nettype none

`include "bounded_array_list_core_assert.svh"

module bal_dp #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bal_pkg::bal_cmd_t                 cmd,
  output bal_pkg::bal_sts_t                      sts,
  input  wire logic [bal_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [bal_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [bal_pkg::WORD_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [bal_pkg::WORD_W-1:0]      out_read_data,
  output logic [bal_pkg::ST_W-1:0]               out_status,
  output logic [CNT_W-1:0]                       out_count,
  output logic signed [bal_pkg::WORD_W-1:0]      out_front_value,
  output logic signed [bal_pkg::WORD_W-1:0]      out_back_value
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (CNT_W > bal_pkg::POS_W) ? CNT_W : bal_pkg::POS_W;

  logic signed [bal_pkg::WORD_W-1:0] mem [DEPTH];

  logic [bal_pkg::REQ_W-1:0]         kind_r;
  logic [bal_pkg::POS_W-1:0]         pos_r;
  logic signed [bal_pkg::WORD_W-1:0] word_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic [CNT_W-1:0]                  idx_r;
  logic [CNT_W-1:0]                  idx_nxt;
  logic signed [bal_pkg::WORD_W-1:0] rda_r;
  logic signed [bal_pkg::WORD_W-1:0] rdb_r;
  logic signed [bal_pkg::WORD_W-1:0] data_r;
  logic [bal_pkg::ST_W-1:0]          stat_r;
  logic                              out_valid_r;
  logic signed [bal_pkg::WORD_W-1:0] out_data_r;
  logic [bal_pkg::ST_W-1:0]          out_stat_r;
  logic [CNT_W-1:0]                  out_cnt_r;
  logic signed [bal_pkg::WORD_W-1:0] out_front_r;
  logic signed [bal_pkg::WORD_W-1:0] out_back_r;

  logic [CW-1:0]            pos_x;
  logic [CW-1:0]            cnt_x;
  logic                     in_range;
  logic                     is_full;
  logic                     is_empty;
  logic [bal_pkg::ST_W-1:0] stat_nxt;
  logic                     rda_en;
  logic                     rdb_en;
  logic [AW-1:0]            rda_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [bal_pkg::WORD_W-1:0] wr_data;

  assign pos_x    = CW'(pos_r);
  assign cnt_x    = CW'(cnt_r);
  assign in_range = pos_x < cnt_x;
  assign is_full  = cnt_r == CNT_W'(DEPTH);
  assign is_empty = cnt_r == '0;

  always_comb begin
    stat_nxt = bal_pkg::ST_OK;
    case (kind_r)
      bal_pkg::REQ_PUSH: begin
        if (is_full) stat_nxt = bal_pkg::ST_FULL;
      end
      bal_pkg::REQ_POP: begin
        if (is_empty) stat_nxt = bal_pkg::ST_EMPTY;
      end
      bal_pkg::REQ_READ, bal_pkg::REQ_ERASE: begin
        if (!in_range) stat_nxt = bal_pkg::ST_RANGE;
      end
      bal_pkg::REQ_INS: begin
        if (!in_range) stat_nxt = bal_pkg::ST_RANGE;
        else if (is_full) stat_nxt = bal_pkg::ST_FULL;
      end
      default: begin
        stat_nxt = bal_pkg::ST_OK;
      end
    endcase
  end

  assign sts.kind     = kind_r;
  assign sts.op_ok    = stat_nxt == bal_pkg::ST_OK;
  assign sts.up_last  = CW'(idx_r - CNT_W'(1)) == pos_x;
  assign sts.dn_last  = (idx_r + CNT_W'(2)) == cnt_r;
  assign sts.ers_tail = (pos_x + CW'(1)) == cnt_x;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    rda_en   = 1'b1;
    rdb_en   = 1'b0;
    rda_addr = '0;
    idx_nxt  = idx_r;
    case (cmd.rd_op)
      bal_pkg::RD_POP: begin
        rda_addr = AW'(cnt_r - CNT_W'(1));
      end
      bal_pkg::RD_POS: begin
        rda_addr = AW'(pos_r);
      end
      bal_pkg::RD_UP_FIRST: begin
        rda_addr = AW'(cnt_r - CNT_W'(1));
        idx_nxt  = cnt_r;
      end
      bal_pkg::RD_UP_NEXT: begin
        rda_addr = AW'(idx_r - CNT_W'(2));
        idx_nxt  = idx_r - CNT_W'(1);
      end
      bal_pkg::RD_DN_FIRST: begin
        rda_addr = AW'(pos_x + CW'(1));
        idx_nxt  = CNT_W'(pos_r);
      end
      bal_pkg::RD_DN_NEXT: begin
        rda_addr = AW'(idx_r + CNT_W'(2));
        idx_nxt  = idx_r + CNT_W'(1);
      end
      bal_pkg::RD_FINAL: begin
        rda_addr = '0;
        rdb_en   = 1'b1;
      end
      default: begin
        rda_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = word_r;
    case (cmd.wr_op)
      bal_pkg::WR_PUSH: begin
        wr_addr = AW'(cnt_r);
      end
      bal_pkg::WR_SHIFT: begin
        wr_addr = AW'(idx_r);
        wr_data = rda_r;
      end
      bal_pkg::WR_INS: begin
        wr_addr = AW'(pos_r);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rda_en) rda_r <= mem[rda_addr];
    if (rdb_en) rdb_r <= mem[AW'(cnt_r - CNT_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_req_type;
      pos_r  <= in_position;
      word_r <= in_value;
    end
    idx_r <= idx_nxt;
    if (cmd.set_data) begin
      stat_r <= stat_nxt;
      data_r <= (stat_nxt == bal_pkg::ST_OK) ? '0 : bal_pkg::ERR_WORD;
    end else if (cmd.cap_data) begin
      data_r <= rda_r;
    end
    if (cmd.out_load) begin
      out_data_r  <= data_r;
      out_stat_r  <= stat_r;
      out_cnt_r   <= cnt_r;
      out_front_r <= is_empty ? bal_pkg::ERR_WORD : rda_r;
      out_back_r  <= is_empty ? bal_pkg::ERR_WORD : rdb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
      else if (cmd.cnt_dec) cnt_r <= cnt_r - CNT_W'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_status      = out_stat_r;
  assign out_count       = out_cnt_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

  `BAL_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "count above depth")
  `BAL_ASSERT_IMPL(a_load_free, cmd.out_load, sts.out_free, "result overwrites word")
  `BAL_ASSERT_NEXT(a_cnt_hold, !(cmd.cnt_inc || cmd.cnt_dec), $stable(cnt_r), "count moved")
  `BAL_ASSERT_IMPL(a_shift_addr, cmd.wr_op == bal_pkg::WR_SHIFT, idx_r < CNT_W'(DEPTH),
                   "shift write past depth")

endmodule

`default_nettype wire

// ===== hdl/bounded_array_list_core.sv =====
// Top level of the bounded array list core: joins bal_ctrl and bal_dp to the
// request and result channels. Depends on bal_pkg, bal_in_if, bal_out_if.
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    req_type, position, value
//   out_ch   out  valid/ready    read_data, status, count, front_value, back_value
//
// One request at a time. Push, errors and unused codes pass through decide, final
// read and result load; pop and read also capture data; insert shifts entries
// from the tail down to position up by one, then writes the new word; erase shifts
// entries above position down unless it erases the tail. The single write port
// of the entry memory moves one entry per cycle during insert and erase shifts.
// Reset clears the count and the result valid; entries are not cleared.
// A result stalled on out_ch holds the next request in its last step until the
// waiting word leaves.
`default_nettype none

module bounded_array_list_core #(
  parameter int DEPTH = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bal_in_if.sink    in_ch,
  bal_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  bal_pkg::bal_cmd_t cmd;
  bal_pkg::bal_sts_t sts;

  bal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bal_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_data   (out_ch.read_data),
    .out_status      (out_ch.status),
    .out_count       (out_ch.count),
    .out_front_value (out_ch.front_value),
    .out_back_value  (out_ch.back_value)
  );

endmodule

`default_nettype wire

// ===== bench/bal_list_checker.sv =====
// Result checker for bounded_array_list_core: watches both channels, keeps a
// shadow copy of the list and compares every result word. Depends on bal_pkg,
// bal_in_if and bal_out_if.
`timescale 1ns / 1ps

module bal_list_checker (
  input  logic clk,
  input  logic rst_n,
  bal_in_if    req_ch,
  bal_out_if   rsp_ch,
  output int   fail_count,
  output int   pending_results,
  output int   list_size
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic signed [bal_pkg::WORD_W-1:0] read_data;
    logic [bal_pkg::ST_W-1:0]          status;
    logic [6:0]                        count;
    logic signed [bal_pkg::WORD_W-1:0] front_value;
    logic signed [bal_pkg::WORD_W-1:0] back_value;
  } list_result_t;

  logic signed [bal_pkg::WORD_W-1:0] shadow_list [DEPTH];
  int                                shadow_len;
  list_result_t                      expected_q [$];
  list_result_t                      got_word;
  list_result_t                      exp_word;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got_v, exp_v, $realtime);
    fail_count = fail_count + 1;
  endtask

  task automatic apply_request(input logic [bal_pkg::REQ_W-1:0] kind,
                               input logic [bal_pkg::POS_W-1:0] pos,
                               input logic signed [bal_pkg::WORD_W-1:0] val,
                               output list_result_t res);
    int p;
    int idx;
    p = int'(pos);
    res.read_data = '0;
    res.status    = bal_pkg::ST_OK;
    case (kind)
      bal_pkg::REQ_PUSH: begin
        if (shadow_len >= DEPTH) begin
          res.status    = bal_pkg::ST_FULL;
          res.read_data = bal_pkg::ERR_WORD;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len = shadow_len + 1;
        end
      end
      bal_pkg::REQ_POP: begin
        if (shadow_len == 0) begin
          res.status    = bal_pkg::ST_EMPTY;
          res.read_data = bal_pkg::ERR_WORD;
        end else begin
          shadow_len    = shadow_len - 1;
          res.read_data = shadow_list[shadow_len];
        end
      end
      bal_pkg::REQ_READ: begin
        if (p >= shadow_len) begin
          res.status    = bal_pkg::ST_RANGE;
          res.read_data = bal_pkg::ERR_WORD;
        end else begin
          res.read_data = shadow_list[p];
        end
      end
      bal_pkg::REQ_INS: begin
        if (p >= shadow_len) begin
          res.status    = bal_pkg::ST_RANGE;
          res.read_data = bal_pkg::ERR_WORD;
        end else if (shadow_len >= DEPTH) begin
          res.status    = bal_pkg::ST_FULL;
          res.read_data = bal_pkg::ERR_WORD;
        end else begin
          for (idx = shadow_len; idx > p; idx--)
            shadow_list[idx] = shadow_list[idx-1];
          shadow_list[p] = val;
          shadow_len = shadow_len + 1;
        end
      end
      bal_pkg::REQ_ERASE: begin
        if (p >= shadow_len) begin
          res.status    = bal_pkg::ST_RANGE;
          res.read_data = bal_pkg::ERR_WORD;
        end else begin
          for (idx = p; idx + 1 < shadow_len; idx++)
            shadow_list[idx] = shadow_list[idx+1];
          shadow_len = shadow_len - 1;
        end
      end
      default: ;
    endcase
    res.count = shadow_len[6:0];
    if (shadow_len == 0) begin
      res.front_value = bal_pkg::ERR_WORD;
      res.back_value  = bal_pkg::ERR_WORD;
    end else begin
      res.front_value = shadow_list[0];
      res.back_value  = shadow_list[shadow_len-1];
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      expected_q.delete();
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_word.read_data   = rsp_ch.read_data;
        got_word.status      = rsp_ch.status;
        got_word.count       = rsp_ch.count;
        got_word.front_value = rsp_ch.front_value;
        got_word.back_value  = rsp_ch.back_value;
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing pending", got_word.read_data, 32'h0);
        end else begin
          exp_word = expected_q.pop_front();
          if (got_word.read_data !== exp_word.read_data)
            report_mismatch("read_data", got_word.read_data, exp_word.read_data);
          if (got_word.status !== exp_word.status)
            report_mismatch("status", 32'(got_word.status), 32'(exp_word.status));
          if (got_word.count !== exp_word.count)
            report_mismatch("count", 32'(got_word.count), 32'(exp_word.count));
          if (got_word.front_value !== exp_word.front_value)
            report_mismatch("front_value", got_word.front_value, exp_word.front_value);
          if (got_word.back_value !== exp_word.back_value)
            report_mismatch("back_value", got_word.back_value, exp_word.back_value);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        apply_request(req_ch.req_type, req_ch.position, req_ch.value, exp_word);
        expected_q = {expected_q, exp_word};
      end
    end
    pending_results <= expected_q.size();
    list_size       <= shadow_len;
  end

endmodule

// ===== bench/tb_bounded_array_list_core.sv =====
// Testbench top for bounded_array_list_core: drives request words with random
// gaps and result backpressure, and gives the verdict from bal_list_checker.
// Depends on bal_pkg, bal_in_if, bal_out_if and bal_list_checker.
`timescale 1ns / 1ps

module tb_bounded_array_list_core;

  localparam logic [bal_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [bal_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [bal_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;
  localparam int PHASE_WORDS = 534;
  localparam int TREND_PERIOD = 320;
  localparam int GROW_SPAN = 140;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   in_idle_pct = 32;
  int   out_idle_pct = 46;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_results;
  int   list_size;

  bal_in_if             req_ch ();
  bal_out_if #(.CNT_W(7)) rsp_ch ();

  bounded_array_list_core #(.DEPTH(64)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  bal_list_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ch          (req_ch),
    .rsp_ch          (rsp_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .list_size       (list_size)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_word(input logic [bal_pkg::REQ_W-1:0] kind,
                           input logic [bal_pkg::POS_W-1:0] pos,
                           input logic signed [bal_pkg::WORD_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.req_type = kind;
    req_ch.position = pos;
    req_ch.value    = val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic random_word(input bit growing, output logic [bal_pkg::REQ_W-1:0] kind,
                             output logic [bal_pkg::POS_W-1:0] pos,
                             output logic signed [bal_pkg::WORD_W-1:0] val);
    int pick;
    int top_pos;
    pick = $urandom_range(0, 99);
    if (growing) begin
      if (pick < 40)      kind = bal_pkg::REQ_PUSH;
      else if (pick < 65) kind = bal_pkg::REQ_INS;
      else if (pick < 80) kind = bal_pkg::REQ_READ;
      else if (pick < 88) kind = bal_pkg::REQ_POP;
      else if (pick < 95) kind = bal_pkg::REQ_ERASE;
      else                kind = REQ_SPARE_A;
    end else begin
      if (pick < 30)      kind = bal_pkg::REQ_POP;
      else if (pick < 58) kind = bal_pkg::REQ_ERASE;
      else if (pick < 75) kind = bal_pkg::REQ_READ;
      else if (pick < 85) kind = bal_pkg::REQ_PUSH;
      else if (pick < 93) kind = bal_pkg::REQ_INS;
      else                kind = REQ_SPARE_A;
    end
    if (kind == REQ_SPARE_A) begin
      case ($urandom_range(0, 2))
        0:       kind = REQ_SPARE_A;
        1:       kind = REQ_SPARE_B;
        default: kind = REQ_SPARE_C;
      endcase
    end
    top_pos = (list_size > 63) ? 63 : list_size;
    if ($urandom_range(0, 4) == 0) pos = bal_pkg::POS_W'($urandom_range(0, 63));
    else                           pos = bal_pkg::POS_W'($urandom_range(0, top_pos));
    case ($urandom_range(0, 7))
      0:       val = 32'sh7fffffff;
      1:       val = 32'sh80000000;
      2:       val = -32'sd1;
      3:       val = 32'sd0;
      default: val = $urandom;
    endcase
  endtask

  initial begin
    logic [bal_pkg::REQ_W-1:0]         kind;
    logic [bal_pkg::POS_W-1:0]         pos;
    logic signed [bal_pkg::WORD_W-1:0] val;
    int                                phase;
    int                                n;
    int                                word_idx;

    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = bal_pkg::REQ_PUSH;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(bal_pkg::REQ_POP,   6'd0,  32'sh5555aaaa);
    send_word(bal_pkg::REQ_READ,  6'd0,  32'sd0);
    send_word(bal_pkg::REQ_INS,   6'd0,  32'sh12345678);
    send_word(bal_pkg::REQ_ERASE, 6'd63, 32'sd0);
    send_word(bal_pkg::REQ_PUSH,  6'd63, 32'sh7fffffff);
    send_word(bal_pkg::REQ_PUSH,  6'd0,  32'sh80000000);
    send_word(bal_pkg::REQ_PUSH,  6'd0,  32'sd0);
    send_word(bal_pkg::REQ_PUSH,  6'd0,  -32'sd1);
    send_word(bal_pkg::REQ_READ,  6'd0,  32'sd0);
    send_word(bal_pkg::REQ_READ,  6'd3,  32'sd0);
    send_word(bal_pkg::REQ_READ,  6'd4,  32'sd0);
    send_word(bal_pkg::REQ_READ,  6'd63, 32'sd0);
    send_word(bal_pkg::REQ_INS,   6'd0,  32'sh55555555);
    send_word(bal_pkg::REQ_INS,   6'd4,  32'shaaaaaaaa);
    send_word(bal_pkg::REQ_INS,   6'd6,  32'sh0badf00d);
    send_word(bal_pkg::REQ_ERASE, 6'd0,  32'sd0);
    send_word(bal_pkg::REQ_ERASE, 6'd5,  32'sd0);
    send_word(bal_pkg::REQ_ERASE, 6'd5,  32'sd0);
    send_word(REQ_SPARE_A,        6'd42, 32'sh7fffffff);
    send_word(REQ_SPARE_B,        6'd21, 32'sh80000000);
    send_word(REQ_SPARE_C,        6'd63, -32'sd1);
    send_word(bal_pkg::REQ_POP,   6'd0,  32'sd0);
    send_word(bal_pkg::REQ_POP,   6'd0,  32'sd0);
    wait_for_results();

    word_idx = 0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 32;
          out_idle_pct = 46;
        end
        1: begin
          in_idle_pct  = 46;
          out_idle_pct = 32;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 1 && n == PHASE_WORDS / 2)
          wait_for_results();
        random_word((word_idx % TREND_PERIOD) < GROW_SPAN, kind, pos, val);
        send_word(kind, pos, val);
        word_idx++;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bal_pkg.sv
hdl/bal_in_if.sv
hdl/bal_out_if.sv
hdl/bal_ctrl.sv
hdl/bal_dp.sv
hdl/bounded_array_list_core.sv
bench/bal_list_checker.sv
bench/tb_bounded_array_list_core.sv
